// ----- sv/fifo_membership_cache_assert.svh -----
// assertion macros for the fifo membership cache
`ifndef FIFO_MEMBERSHIP_CACHE_ASSERT_SVH
`define FIFO_MEMBERSHIP_CACHE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// condition holds in the same cycle
`define FMC_ASSERT_NOW(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// antecedent implies consequent in the same cycle
`define FMC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// antecedent implies consequent in the next cycle
`define FMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FMC_ASSERT_NOW(label, clk, rst, cond, msg)
`define FMC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define FMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- sv/fmc_pkg.sv -----
// shared types and constants for the fifo membership cache
package fmc_pkg;
   // default sizing
   localparam int CAPACITY_DEF   = 16;
   localparam int IDENT_BITS_DEF = 32;

   // fixed port widths
   localparam int ID_W       = 32;
   localparam int CNT_W      = 5;
   localparam int CFG_W      = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // register map, indexed by word address
   localparam logic REG_CAPACITY = 1'b0;
   localparam logic [CFG_W-1:0] CAPACITY_RESET = 5'd16;

   // opcodes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DUMP   = 1'b1;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic shift;
      logic rotate;
   } fmc_cell_cmd_type;

   // status reported by each cell
   typedef struct packed {
      logic match;
      logic tail;
   } fmc_cell_flags_type;
endpackage

// ----- sv/fmc_cell.sv -----
// one cell of the identifier chain: holds one entry, shifts or rotates it
module fmc_cell #(
   parameter int IDENT_BITS = 32,
   parameter int OCC_W      = 5,
   parameter int INDEX      = 0
) (
   input  logic                       clock,
   input  fmc_pkg::fmc_cell_cmd_type  cmd,
   input  logic [OCC_W-1:0]           occupancy,
   input  logic [IDENT_BITS-1:0]      probe,
   input  logic [IDENT_BITS-1:0]      from_newer,
   input  logic [IDENT_BITS-1:0]      from_older,
   input  logic [IDENT_BITS-1:0]      head,
   output logic [IDENT_BITS-1:0]      ident_out,
   output fmc_pkg::fmc_cell_flags_type flags
);
   import fmc_pkg::*;

   localparam logic [OCC_W-1:0] POS_IDX  = OCC_W'(INDEX);
   localparam logic [OCC_W-1:0] POS_NEXT = OCC_W'(INDEX + 1);

   logic [IDENT_BITS-1:0] ident_ff;
   logic [IDENT_BITS-1:0] ident_in;
   logic                  occupied;

   // position flags against the current fill level
   assign occupied    = POS_IDX < occupancy;
   assign flags.tail  = POS_NEXT == occupancy;
   assign flags.match = occupied && (ident_ff == probe);
   assign ident_out   = ident_ff;

   // insert moves entries toward older, dump rotates the occupied ring
   always_comb begin
      if (cmd.shift) begin
         ident_in = from_newer;
      end else if (cmd.rotate) begin
         ident_in = flags.tail ? head : from_older;
      end else begin
         ident_in = ident_ff;
      end
   end

   always_ff @(posedge clock) begin
      ident_ff <= ident_in;
   end
endmodule

// ----- sv/fmc_chain.sv -----
// row of cells, newest entry in cell zero, with hit and oldest-entry lookup
module fmc_chain #(
   parameter int CAPACITY   = 16,
   parameter int IDENT_BITS = 32,
   parameter int OCC_W      = 5
) (
   input  logic                      clock,
   input  fmc_pkg::fmc_cell_cmd_type cmd,
   input  logic [OCC_W-1:0]          occupancy,
   input  logic [IDENT_BITS-1:0]     new_ident,
   output logic                      hit,
   output logic [IDENT_BITS-1:0]     tail_ident,
   output logic [IDENT_BITS-1:0]     head_ident
);
   import fmc_pkg::*;

   logic [IDENT_BITS-1:0] cell_ident [CAPACITY];
   fmc_cell_flags_type    cell_flags [CAPACITY];

   // cells with their neighbor links
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [IDENT_BITS-1:0] newer;
      logic [IDENT_BITS-1:0] older;
      if (i == 0) begin : g_first
         assign newer = new_ident;
      end else begin : g_mid
         assign newer = cell_ident[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign older = cell_ident[i];
      end else begin : g_inner
         assign older = cell_ident[i+1];
      end
      fmc_cell #(
         .IDENT_BITS (IDENT_BITS),
         .OCC_W      (OCC_W),
         .INDEX      (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .occupancy  (occupancy),
         .probe      (new_ident),
         .from_newer (newer),
         .from_older (older),
         .head       (cell_ident[0]),
         .ident_out  (cell_ident[i]),
         .flags      (cell_flags[i])
      );
   end

   // or-reduce matches and select the oldest entry
   always_comb begin
      hit        = 1'b0;
      tail_ident = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit        = hit | cell_flags[i].match;
         tail_ident = tail_ident | (cell_ident[i] & {IDENT_BITS{cell_flags[i].tail}});
      end
   end

   assign head_ident = cell_ident[0];
endmodule

// ----- sv/fifo_membership_cache.sv -----
// top level of the fifo membership cache
//
// Holds up to capacity_in_use identifiers in arrival order in a row of cells,
// newest in cell zero. A transaction is taken when start is high and busy low.
// Insert (op 0): the identifier is compared against every held cell at once;
// one result follows in the next cycle with hit, or with the evicted oldest
// identifier when the set was full. Inserts are taken every cycle while busy is low.
// Dump (op 1): with n entries held, busy stays high until all n entries are read
// out and each result follows in the cycle after its read, newest first, last set
// on the final one; the chain rotates one position a cycle and is back in place
// at the end. An empty dump gives one result in the next cycle, entry_valid clear.
// Results appear for exactly one cycle on rsp_valid; there is no backpressure.
// Reset empties the set and sets capacity_in_use to 16; no clearing pass is
// needed. The capacity register sits at address 0 of the APB port and should
// be written only while the block is idle.
module fifo_membership_cache #(
   parameter int CAPACITY   = fmc_pkg::CAPACITY_DEF,
   parameter int IDENT_BITS = fmc_pkg::IDENT_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // command channel
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_op,
   input  logic [fmc_pkg::ID_W-1:0]       req_ident,
   // result channel
   output logic                           rsp_valid,
   output logic                           rsp_hit,
   output logic                           rsp_evicted_valid,
   output logic [fmc_pkg::ID_W-1:0]       rsp_evicted_ident,
   output logic [fmc_pkg::CNT_W-1:0]      rsp_held_count,
   output logic                           rsp_entry_valid,
   output logic [fmc_pkg::ID_W-1:0]       rsp_entry_ident,
   output logic                           rsp_last,
   // register port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [fmc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [fmc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [fmc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import fmc_pkg::*;

`include "fifo_membership_cache_assert.svh"

   localparam int OCC_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;
   localparam logic [CMP_W-1:0] CAP_MAX = CMP_W'(CAPACITY);
   localparam logic [CMP_W-1:0] CAP_ONE = CMP_W'(1);
   localparam logic [OCC_W-1:0] OCC_ONE = OCC_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DUMP = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   logic [OCC_W-1:0]      occ_ff, occ_in;
   logic [OCC_W-1:0]      count_ff, count_in;
   logic [CFG_W-1:0]      cap_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  hit_ff, hit_in;
   logic                  ev_valid_ff, ev_valid_in;
   logic [ID_W-1:0]       ev_ident_ff, ev_ident_in;
   logic [CNT_W-1:0]      held_ff, held_in;
   logic                  en_valid_ff, en_valid_in;
   logic [ID_W-1:0]       en_ident_ff, en_ident_in;
   logic                  last_ff, last_in;

   logic                  accept;
   logic                  csr_write;
   logic [CMP_W-1:0]      cap_wide;
   logic [CMP_W-1:0]      eff_cap;
   logic                  full;
   logic [IDENT_BITS+ID_W-1:0] ident_wide;
   logic [IDENT_BITS-1:0] new_ident;
   logic                  chain_hit;
   logic [IDENT_BITS-1:0] tail_ident;
   logic [IDENT_BITS-1:0] head_ident;
   logic [IDENT_BITS+ID_W-1:0] tail_wide;
   logic [IDENT_BITS+ID_W-1:0] head_wide;
   fmc_cell_cmd_type      cmd;

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
   assign prdata    = (psel && (paddr[2] == REG_CAPACITY)) ? CSR_DATA_W'(cap_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAPACITY_RESET;
      end else if (csr_write) begin
         cap_ff <= pwdata[CFG_W-1:0];
      end
   end

   // effective capacity, zero acts as one, saturated at the cell count
   always_comb begin
      cap_wide = CMP_W'(cap_ff);
      if (cap_wide == '0) begin
         eff_cap = CAP_ONE;
      end else if (cap_wide > CAP_MAX) begin
         eff_cap = CAP_MAX;
      end else begin
         eff_cap = cap_wide;
      end
   end
   assign full = CMP_W'(occ_ff) >= eff_cap;

   // identifier width adaption
   assign ident_wide = {{IDENT_BITS{1'b0}}, req_ident};
   assign new_ident  = ident_wide[IDENT_BITS-1:0];
   assign tail_wide  = {{ID_W{1'b0}}, tail_ident};
   assign head_wide  = {{ID_W{1'b0}}, head_ident};

   assign busy   = (state_ff == ST_DUMP);
   assign accept = start && !busy;

   // cell chain
   fmc_chain #(
      .CAPACITY   (CAPACITY),
      .IDENT_BITS (IDENT_BITS),
      .OCC_W      (OCC_W)
   ) u_chain (
      .clock      (clock),
      .cmd        (cmd),
      .occupancy  (occ_ff),
      .new_ident  (new_ident),
      .hit        (chain_hit),
      .tail_ident (tail_ident),
      .head_ident (head_ident)
   );

   // control and result formation
   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      count_in     = count_ff;
      cmd.shift    = 1'b0;
      cmd.rotate   = 1'b0;
      rsp_valid_in = 1'b0;
      hit_in       = 1'b0;
      ev_valid_in  = 1'b0;
      ev_ident_in  = '0;
      held_in      = CNT_W'(occ_ff);
      en_valid_in  = 1'b0;
      en_ident_in  = '0;
      last_in      = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_op == OP_INSERT)) begin
               rsp_valid_in = 1'b1;
               if (chain_hit) begin
                  hit_in = 1'b1;
               end else begin
                  cmd.shift = 1'b1;
                  if (full) begin
                     ev_valid_in = 1'b1;
                     ev_ident_in = tail_wide[ID_W-1:0];
                  end else begin
                     occ_in = occ_ff + OCC_ONE;
                  end
                  held_in = full ? CNT_W'(occ_ff) : CNT_W'(occ_ff + OCC_ONE);
               end
            end else if (accept) begin
               if (occ_ff == '0) begin
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = ST_DUMP;
                  count_in = occ_ff;
               end
            end
         end
         ST_DUMP: begin
            rsp_valid_in = 1'b1;
            en_valid_in  = 1'b1;
            en_ident_in  = head_wide[ID_W-1:0];
            last_in      = (count_ff == OCC_ONE);
            cmd.rotate   = 1'b1;
            count_in     = count_ff - OCC_ONE;
            if (count_ff == OCC_ONE) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload registers
   always_ff @(posedge clock) begin
      hit_ff      <= hit_in;
      ev_valid_ff <= ev_valid_in;
      ev_ident_ff <= ev_ident_in;
      held_ff     <= held_in;
      en_valid_ff <= en_valid_in;
      en_ident_ff <= en_ident_in;
      last_ff     <= last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_evicted_valid = ev_valid_ff;
   assign rsp_evicted_ident = ev_ident_ff;
   assign rsp_held_count    = held_ff;
   assign rsp_entry_valid   = en_valid_ff;
   assign rsp_entry_ident   = en_ident_ff;
   assign rsp_last          = last_ff;

   // checks
   `FMC_ASSERT_NOW(a_occ_range, clock, reset, occ_ff <= OCC_W'(CAPACITY), "occupancy overflow")
   `FMC_ASSERT_NEXT(a_dump_streams, clock, reset, busy, rsp_valid && rsp_entry_valid, "dump gap")
   `FMC_ASSERT_NEXT(a_insert_result, clock, reset, start && !busy && (req_op == OP_INSERT), rsp_valid && rsp_last, "insert result missing")
   `FMC_ASSERT_IMPLIES(a_evict_no_hit, clock, reset, rsp_valid && rsp_evicted_valid, !rsp_hit && !rsp_entry_valid, "eviction on hit")
endmodule
